@@ hdl/fmpd_pkg.sv @@
package fmpd_pkg;

   localparam int unsigned RES_W     = 30;
   localparam int unsigned EXP_WIDTH = 32;

   localparam logic [RES_W-1:0] PRIME_MOD  = 30'd1000000007;
   // floor(2^61 / PRIME_MOD)
   localparam logic [31:0]      BARRETT_MU = 32'd2305842993;

   typedef logic [RES_W-1:0]          res_type;
   typedef logic [3:0][RES_W-1:0]     mat_type;
   typedef logic [EXP_WIDTH-1:0]      exp_type;

   typedef struct packed {
      logic    done;
      res_type value;
   } mm_res_type;

   typedef struct packed {
      logic    done;
      mat_type value;
   } mm_mat_type;

   // row-major 2x2, entry 0 is top-left
   localparam mat_type MAT_IDENT = {30'd1, 30'd0, 30'd0, 30'd1};
   localparam mat_type MAT_FIB   = {30'd1, 30'd1, 30'd1, 30'd0};

   function automatic exp_type exp_trim(input logic [31:0] v);
      logic [EXP_WIDTH+31:0] wide;
      wide = {{EXP_WIDTH{1'b0}}, v};
      return wide[EXP_WIDTH-1:0];
   endfunction

endpackage

@@ hdl/fmpd_mulmod.sv @@
module fmpd_mulmod (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  fmpd_pkg::res_type    a1,
   input  fmpd_pkg::res_type    b1,
   input  fmpd_pkg::res_type    a2,
   input  fmpd_pkg::res_type    b2,
   output fmpd_pkg::mm_res_type res
);

   // (a1*b1 + a2*b2) mod p on one 32x32 multiplier, Barrett reduction
   typedef enum logic [2:0] {
      PH_IDLE, PH_MUL1, PH_MUL2, PH_ADD, PH_QEST, PH_QMUL, PH_SUB, PH_FIX
   } phase_type;

   localparam logic [31:0] P1 = {2'b00, fmpd_pkg::PRIME_MOD};
   localparam logic [31:0] P2 = {1'b0, fmpd_pkg::PRIME_MOD, 1'b0};

   phase_type         phase_ff, phase_in;
   logic [63:0]       prod_ff;
   logic [59:0]       part_ff, part_in;
   logic [60:0]       sum_ff, sum_in;
   logic [31:0]       rem_ff, rem_in;
   fmpd_pkg::res_type val_ff, val_in;
   logic              done_ff, done_in;
   logic [31:0]       mul_a, mul_b;
   logic [31:0]       fix_val;

   always_comb begin
      case (phase_ff)
         PH_MUL1: begin
            mul_a = {2'b00, a1};
            mul_b = {2'b00, b1};
         end
         PH_MUL2: begin
            mul_a = {2'b00, a2};
            mul_b = {2'b00, b2};
         end
         PH_QEST: begin
            mul_a = sum_ff[60:29];
            mul_b = fmpd_pkg::BARRETT_MU;
         end
         PH_QMUL: begin
            mul_a = prod_ff[63:32];
            mul_b = P1;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      if (rem_ff >= P2) begin
         fix_val = rem_ff - P2;
      end else if (rem_ff >= P1) begin
         fix_val = rem_ff - P1;
      end else begin
         fix_val = rem_ff;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      part_in  = part_ff;
      sum_in   = sum_ff;
      rem_in   = rem_ff;
      val_in   = val_ff;
      done_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_MUL1;
            end
         end
         PH_MUL1: phase_in = PH_MUL2;
         PH_MUL2: begin
            part_in  = prod_ff[59:0];
            phase_in = PH_ADD;
         end
         PH_ADD: begin
            sum_in   = {1'b0, part_ff} + {1'b0, prod_ff[59:0]};
            phase_in = PH_QEST;
         end
         PH_QEST: phase_in = PH_QMUL;
         PH_QMUL: phase_in = PH_SUB;
         PH_SUB: begin
            // quotient estimate is low by at most two, so r < 3p
            rem_in   = sum_ff[31:0] - prod_ff[31:0];
            phase_in = PH_FIX;
         end
         PH_FIX: begin
            val_in   = fix_val[fmpd_pkg::RES_W-1:0];
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      prod_ff <= mul_a * mul_b;
      part_ff <= part_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      val_ff  <= val_in;
   end

   assign res.done  = done_ff;
   assign res.value = val_ff;

endmodule

@@ hdl/fmpd_matmul.sv @@
module fmpd_matmul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  fmpd_pkg::mat_type    x,
   input  fmpd_pkg::mat_type    y,
   output fmpd_pkg::mm_mat_type res
);

   logic                 busy_ff, busy_in;
   logic [1:0]           ent_ff, ent_in;
   logic                 go_ff, go_in;
   logic                 done_ff, done_in;
   fmpd_pkg::mat_type    acc_ff, acc_in;
   fmpd_pkg::mm_res_type unit_res;

   // entry (i,j) = x[i][0]*y[0][j] + x[i][1]*y[1][j]
   fmpd_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .start (go_ff),
      .a1    (x[{ent_ff[1], 1'b0}]),
      .b1    (y[{1'b0, ent_ff[0]}]),
      .a2    (x[{ent_ff[1], 1'b1}]),
      .b2    (y[{1'b1, ent_ff[0]}]),
      .res   (unit_res)
   );

   always_comb begin
      busy_in = busy_ff;
      ent_in  = ent_ff;
      go_in   = 1'b0;
      done_in = 1'b0;
      acc_in  = acc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            ent_in  = '0;
            go_in   = 1'b1;
         end
      end else if (unit_res.done) begin
         acc_in[ent_ff] = unit_res.value;
         if (ent_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            ent_in = ent_ff + 2'd1;
            go_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ent_ff  <= '0;
         go_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ent_ff  <= ent_in;
         go_ff   <= go_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
   end

   assign res.done  = done_ff;
   assign res.value = acc_ff;

endmodule

@@ hdl/fib_matrix_power_difference_mod.sv @@
// Fibonacci matrix power difference, modulo 1000000007.
// Input stream req_: one word carries n_index and exponent_k. The block forms
// P = M^(n+1) with M = [[0,1],[1,1]], D = P - M, and returns the bottom-right
// entry of D^k on the rsp_ stream, one result word per request word.
// Both powers run square-and-multiply, least significant exponent bit first,
// on one 2x2 product sequencer that drives a single 32x32 multiplier with
// Barrett reduction, and forms the four entries of a product one after
// another. An exponent bit costs one product (squaring) plus one more when
// the bit is set; the square after the top set bit is skipped. Latency
// grows with the products for n+1 plus the products for k; k = 0 answers 1.
// The exponent n+1 is formed in 32 bits and wraps to 0 for n = 2^32-1.
// One request is in flight at a time: req_tready is high only while idle.
// A finished result sits in the rsp_ output register; a new request is taken
// while it waits, and if rsp_tready stays low the next result holds until the
// register frees up. Reset (synchronous, active high) drops rsp_tvalid and
// returns the sequencer to idle.
module fib_matrix_power_difference_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] n_index, [63:32] exponent_k
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [29:0] result_value, [31:30] zero
);

   typedef enum logic [2:0] {
      S_IDLE, S_STEP, S_WAIT_ACC, S_WAIT_SQ, S_DIFF, S_DONE
   } state_type;

   state_type            state_ff, state_in;
   fmpd_pkg::mat_type    acc_ff, acc_in;
   fmpd_pkg::mat_type    sq_ff, sq_in;
   fmpd_pkg::exp_type    rem_ff, rem_in;
   fmpd_pkg::exp_type    kexp_ff, kexp_in;
   logic                 second_ff, second_in;
   logic                 mm_start_ff, mm_start_in;
   logic                 sel_acc_ff, sel_acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   fmpd_pkg::res_type    rsp_data_ff, rsp_data_in;
   fmpd_pkg::mm_mat_type mm_res;
   fmpd_pkg::mat_type    diff;

   fmpd_matmul u_matmul (
      .clock (clock),
      .reset (reset),
      .start (mm_start_ff),
      .x     (sel_acc_ff ? acc_ff : sq_ff),
      .y     (sq_ff),
      .res   (mm_res)
   );

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (acc_ff[i] >= fmpd_pkg::MAT_FIB[i]) begin
            diff[i] = acc_ff[i] - fmpd_pkg::MAT_FIB[i];
         end else begin
            diff[i] = acc_ff[i] + fmpd_pkg::PRIME_MOD - fmpd_pkg::MAT_FIB[i];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      kexp_in      = kexp_ff;
      second_in    = second_ff;
      mm_start_in  = 1'b0;
      sel_acc_in   = sel_acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               acc_in    = fmpd_pkg::MAT_IDENT;
               sq_in     = fmpd_pkg::MAT_FIB;
               rem_in    = fmpd_pkg::exp_trim(req_tdata[31:0] + 32'd1);
               kexp_in   = fmpd_pkg::exp_trim(req_tdata[63:32]);
               second_in = 1'b0;
               state_in  = S_STEP;
            end
         end
         S_STEP: begin
            if (rem_ff == '0) begin
               state_in = second_ff ? S_DONE : S_DIFF;
            end else if (rem_ff[0]) begin
               sel_acc_in  = 1'b1;
               mm_start_in = 1'b1;
               state_in    = S_WAIT_ACC;
            end else begin
               sel_acc_in  = 1'b0;
               mm_start_in = 1'b1;
               state_in    = S_WAIT_SQ;
            end
         end
         S_WAIT_ACC: begin
            if (mm_res.done) begin
               acc_in = mm_res.value;
               if (rem_ff[fmpd_pkg::EXP_WIDTH-1:1] != '0) begin
                  sel_acc_in  = 1'b0;
                  mm_start_in = 1'b1;
                  state_in    = S_WAIT_SQ;
               end else begin
                  rem_in   = '0;
                  state_in = S_STEP;
               end
            end
         end
         S_WAIT_SQ: begin
            if (mm_res.done) begin
               sq_in    = mm_res.value;
               rem_in   = rem_ff >> 1;
               state_in = S_STEP;
            end
         end
         S_DIFF: begin
            sq_in     = diff;
            acc_in    = fmpd_pkg::MAT_IDENT;
            rem_in    = kexp_ff;
            second_in = 1'b1;
            state_in  = S_STEP;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff[3];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         second_ff    <= 1'b0;
         mm_start_ff  <= 1'b0;
         sel_acc_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         mm_start_ff  <= mm_start_in;
         sel_acc_ff   <= sel_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      kexp_ff     <= kexp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

`ifndef NO_ASSERTIONS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mm_res.done |-> (state_ff == S_WAIT_ACC || state_ff == S_WAIT_SQ))
      else $error("matrix product finished outside a wait state");

   a_rsp_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff < fmpd_pkg::PRIME_MOD))
      else $error("result word not reduced");

   a_second_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP && rem_ff == '0 && second_ff) |=> (state_ff == S_DONE))
      else $error("second power did not finish");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_STEP && !second_ff))
      else $error("accepted word did not start the first power");
`endif

endmodule

@@ tb/tb_fib_matrix_power_difference_mod.sv @@
`timescale 1ns / 100ps

module tb_fib_matrix_power_difference_mod;

   localparam int unsigned RANDOM_WORDS = 520;
   localparam int unsigned QUIET_TAIL   = 60;
   localparam longint unsigned CYCLE_LIMIT = 12_000_000;

   typedef struct {
      logic [31:0] n_index;
      logic [31:0] exponent_k;
      bit          drain;
   } fib_req_type;

   typedef struct {
      logic [31:0]       n_index;
      logic [31:0]       exponent_k;
      fmpd_pkg::res_type value;
   } fib_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] n_index, [63:32] exponent_k
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [29:0] result_value, [31:30] zero

   fib_req_type pending_words[$];
   fib_rsp_type expected_values[$];
   int unsigned error_count = 0;
   longint unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned recv_stall = 0;

   fib_matrix_power_difference_mod i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic fmpd_pkg::mat_type mod_mat_mul(input fmpd_pkg::mat_type x,
                                                     input fmpd_pkg::mat_type y);
      fmpd_pkg::mat_type r;
      logic [63:0]       a;
      logic [63:0]       b;
      logic [63:0]       prime;
      prime = 64'(fmpd_pkg::PRIME_MOD);
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            a = (64'(x[i*2]) * 64'(y[j])) % prime;
            b = (64'(x[i*2+1]) * 64'(y[2+j])) % prime;
            r[i*2+j] = fmpd_pkg::res_type'((a + b) % prime);
         end
      end
      return r;
   endfunction

   function automatic fmpd_pkg::mat_type mod_mat_pow(input fmpd_pkg::mat_type base,
                                                     input fmpd_pkg::exp_type e);
      fmpd_pkg::mat_type acc;
      fmpd_pkg::mat_type sq;
      fmpd_pkg::exp_type rem;
      acc = fmpd_pkg::MAT_IDENT;
      sq  = base;
      rem = e;
      for (int b = 0; b < fmpd_pkg::EXP_WIDTH && rem != 0; b++) begin
         if (rem[0]) begin
            acc = mod_mat_mul(acc, sq);
         end
         sq  = mod_mat_mul(sq, sq);
         rem = rem >> 1;
      end
      return acc;
   endfunction

   function automatic fmpd_pkg::res_type fib_diff_power(input logic [31:0] n,
                                                        input logic [31:0] k);
      logic [31:0]       first_exp;
      fmpd_pkg::mat_type p;
      fmpd_pkg::mat_type diff;
      fmpd_pkg::mat_type dk;
      logic [63:0]       prime;
      prime     = 64'(fmpd_pkg::PRIME_MOD);
      first_exp = n + 32'd1;
      p = mod_mat_pow(fmpd_pkg::MAT_FIB, fmpd_pkg::exp_type'(first_exp));
      for (int i = 0; i < 4; i++) begin
         diff[i] = fmpd_pkg::res_type'((64'(p[i]) + prime - 64'(fmpd_pkg::MAT_FIB[i]))
                                       % prime);
      end
      dk = mod_mat_pow(diff, fmpd_pkg::exp_type'(k));
      return dk[3];
   endfunction

   // mostly short exponents to keep the run short, some at full width
   function automatic logic [31:0] rand_operand();
      int unsigned w;
      if ($urandom_range(0, 9) == 0) begin
         return $urandom;
      end
      w = $urandom_range(0, 10);
      return $urandom & ((32'd1 << w) - 32'd1);
   endfunction

   task automatic add_word(input logic [31:0] n, input logic [31:0] k, input bit drain);
      fib_req_type w;
      w.n_index    = n;
      w.exponent_k = k;
      w.drain      = drain;
      pending_words.push_back(w);
   endtask

   // request driver
   always @(posedge clock) begin
      fib_rsp_type exp_word;
      fib_req_type w;
      logic        next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            exp_word.n_index    = req_tdata[31:0];
            exp_word.exponent_k = req_tdata[63:32];
            exp_word.value      = fib_diff_power(req_tdata[31:0], req_tdata[63:32]);
            expected_values.push_back(exp_word);
         end
         if (!(req_tvalid && !req_tready)) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_words.size() != 0) begin
               if (pending_words[0].drain && expected_values.size() != 0) begin
                  // hold off until the block has drained
               end else if (pending_words.size() > QUIET_TAIL &&
                            $urandom_range(0, 4) == 0) begin
                  send_gap = $urandom_range(1, 7) - 1;
               end else begin
                  w = pending_words.pop_front();
                  req_tdata  <= {w.exponent_k, w.n_index};
                  next_valid = 1'b1;
               end
            end
            req_tvalid <= next_valid;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      fib_rsp_type exp_word;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_values.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got %0d",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               exp_word = expected_values.pop_front();
               if (rsp_tdata !== {2'b00, exp_word.value}) begin
                  $display("%0t: result_value mismatch n=%0d k=%0d: expected %0d, got %0d",
                           $time, exp_word.n_index, exp_word.exponent_k,
                           {2'b00, exp_word.value}, rsp_tdata);
                  error_count++;
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            recv_stall = $urandom_range(1, 7) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      add_word(32'd0, 32'd0, 1'b0);
      add_word(32'd0, 32'd1, 1'b0);
      add_word(32'd0, 32'hFFFFFFFF, 1'b0);
      add_word(32'd1, 32'd0, 1'b0);
      add_word(32'd1, 32'd1, 1'b0);
      add_word(32'd1, 32'd2, 1'b0);
      add_word(32'd2, 32'd3, 1'b0);
      add_word(32'd10, 32'd5, 1'b0);
      add_word(32'hFFFFFFFF, 32'd0, 1'b0);
      add_word(32'hFFFFFFFF, 32'd1, 1'b0);
      add_word(32'hFFFFFFFF, 32'd2, 1'b0);
      add_word(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
      add_word(32'hFFFFFFFE, 32'hFFFFFFFF, 1'b0);
      add_word(32'hFFFFFFFE, 32'd1, 1'b0);
      add_word(32'h7FFFFFFF, 32'h80000000, 1'b0);
      add_word(32'h80000000, 32'h7FFFFFFF, 1'b0);
      add_word(32'hAAAAAAAA, 32'h55555555, 1'b0);
      add_word(32'h55555555, 32'hAAAAAAAA, 1'b0);
      add_word(32'd123456, 32'd0, 1'b0);
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            add_word(rand_operand(), 32'd0, i == 0 || i == RANDOM_WORDS / 2);
         end else begin
            add_word(rand_operand(), rand_operand(), i == 0 || i == RANDOM_WORDS / 2);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_values.size() != 0) begin
         @(posedge clock);
      end
      repeat (100) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
